// ===== rtl/flv_pkg.sv =====
// flv_pkg: shared types, codes and reset values for the flow action list validator
`default_nettype none
package flv_pkg;

    // default number of built-in action types held in the length table
    localparam int TABLE_ENTRIES_DEF = 16;

    // header granule in bytes
    localparam logic [15:0] HDR_BYTES = 16'd8;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_TYPE   = 3'd1;
    localparam logic [2:0] ST_BAD_LEN    = 3'd2;
    localparam logic [2:0] ST_BAD_VENDOR = 3'd3;
    localparam logic [2:0] ST_BAD_PORT   = 3'd4;

    // request modes
    localparam logic MODE_BEGIN  = 1'b0;
    localparam logic MODE_ACTION = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_LENGTH_TABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUILTIN_TYPE_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VENDOR_TYPE_CODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPTED_VENDOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NO_PORT_VALUE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_TYPE_CODE   = 3'd5;

    // configuration reset values
    localparam logic [63:0] RST_TYPE_LENGTH_TABLE  = 64'd73301889297;
    localparam logic [4:0]  RST_BUILTIN_TYPE_COUNT = 5'd10;
    localparam logic [15:0] RST_VENDOR_TYPE_CODE   = 16'hFFFF;
    localparam logic [31:0] RST_ACCEPTED_VENDOR    = 32'd8992;
    localparam logic [15:0] RST_NO_PORT_VALUE      = 16'hFFFF;
    localparam logic [3:0]  RST_OUTPUT_TYPE_CODE   = 4'd0;

    // one request: a list begin or one action header
    typedef struct packed {
        logic        mode;
        logic [15:0] list_length;
        logic [15:0] ingress_port;
        logic [15:0] action_type;
        logic [15:0] action_len;
        logic [15:0] target_port;
        logic [31:0] vendor_word;
    } flv_req_t;

    // one result
    typedef struct packed {
        logic [2:0] status;
        logic       done_res;
    } flv_rsp_t;

    // scalar configuration seen by the checker
    typedef struct packed {
        logic [4:0]  builtin_type_count;
        logic [15:0] vendor_type_code;
        logic [31:0] accepted_vendor;
        logic [15:0] no_port_value;
        logic [3:0]  output_type_code;
    } flv_cfg_t;

endpackage
`default_nettype wire

// ===== rtl/flv_core.sv =====
// flv_core: per-list state and the combinational action header check
`default_nettype none
module flv_core #(
    parameter int TABLE_ENTRIES = flv_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         fire,
    input  wire flv_pkg::flv_req_t            req,
    input  wire logic [4*TABLE_ENTRIES-1:0]   tbl,
    input  wire flv_pkg::flv_cfg_t            cfg,
    output flv_pkg::flv_rsp_t                 rsp
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [4:0] ENTRIES_CNT = 5'(TABLE_ENTRIES);

    logic [15:0] bytes_left_reg;
    logic [15:0] bytes_left_next;
    logic [15:0] saved_ingress_reg;
    logic [15:0] saved_ingress_next;
    logic        list_active_reg;
    logic        list_active_next;
    logic [2:0]  final_status_reg;
    logic [2:0]  final_status_next;

    logic [4:0]       type_count;
    logic             type_builtin;
    logic [IDX_W-1:0] tbl_idx;
    logic [3:0]       units;
    logic             len_bad;
    logic [2:0]       hdr_status;
    logic [15:0]      bytes_after;
    logic [2:0]       status;
    logic             done;

    // type count saturates at the table size
    assign type_count   = (cfg.builtin_type_count > ENTRIES_CNT) ? ENTRIES_CNT
                                                                 : cfg.builtin_type_count;
    assign type_builtin = (req.action_type < {11'd0, type_count});
    assign tbl_idx      = req.action_type[IDX_W-1:0];

    // required length in 8-byte units, only looked up for built-in types
    always_comb
    begin
        units = 4'd0;
        if (type_builtin)
        begin
            units = tbl[{tbl_idx, 2'b00} +: 4];
        end
    end

    // length framing: nonzero, fits, multiple of the header size
    assign len_bad = (req.action_len == 16'd0) || (req.action_len > bytes_left_reg) ||
                     (req.action_len[2:0] != 3'd0);

    // header check in priority order
    always_comb
    begin
        if (len_bad)
        begin
            hdr_status = flv_pkg::ST_BAD_LEN;
        end
        else if (type_builtin)
        begin
            if (units == 4'd0)
            begin
                hdr_status = flv_pkg::ST_BAD_TYPE;
            end
            else if (req.action_len != {9'd0, units, 3'd0})
            begin
                hdr_status = flv_pkg::ST_BAD_LEN;
            end
            else if ((req.action_type == {12'd0, cfg.output_type_code}) &&
                     ((req.target_port == cfg.no_port_value) ||
                      (req.target_port == saved_ingress_reg)))
            begin
                hdr_status = flv_pkg::ST_BAD_PORT;
            end
            else
            begin
                hdr_status = flv_pkg::ST_OK;
            end
        end
        else if (req.action_type == cfg.vendor_type_code)
        begin
            hdr_status = (req.vendor_word != cfg.accepted_vendor) ? flv_pkg::ST_BAD_VENDOR
                                                                  : flv_pkg::ST_OK;
        end
        else
        begin
            hdr_status = flv_pkg::ST_BAD_TYPE;
        end
    end

    assign bytes_after = bytes_left_reg - req.action_len;

    // step: begin, orphan action, or checked action
    always_comb
    begin
        bytes_left_next    = bytes_left_reg;
        saved_ingress_next = saved_ingress_reg;
        list_active_next   = list_active_reg;
        final_status_next  = final_status_reg;
        status             = flv_pkg::ST_OK;
        done               = 1'b0;
        if (req.mode == flv_pkg::MODE_BEGIN)
        begin
            bytes_left_next    = req.list_length;
            saved_ingress_next = req.ingress_port;
            done               = (req.list_length < flv_pkg::HDR_BYTES);
            status             = (done && (req.list_length != 16'd0)) ? flv_pkg::ST_BAD_LEN
                                                                     : flv_pkg::ST_OK;
            list_active_next   = !done;
            if (done)
            begin
                final_status_next = status;
            end
        end
        else if (!list_active_reg)
        begin
            status = final_status_reg;
            done   = 1'b1;
        end
        else
        begin
            if (hdr_status != flv_pkg::ST_OK)
            begin
                status = hdr_status;
                done   = 1'b1;
            end
            else
            begin
                bytes_left_next = bytes_after;
                done            = (bytes_after < flv_pkg::HDR_BYTES);
                status          = (done && (bytes_after != 16'd0)) ? flv_pkg::ST_BAD_LEN
                                                                  : flv_pkg::ST_OK;
            end
            if (done)
            begin
                list_active_next  = 1'b0;
                final_status_next = status;
            end
        end
    end

    assign rsp.status   = status;
    assign rsp.done_res = done;

    // list state, updated only when a request moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg    <= 16'd0;
            saved_ingress_reg <= 16'd0;
            list_active_reg   <= 1'b0;
            final_status_reg  <= flv_pkg::ST_OK;
        end
        else if (fire)
        begin
            bytes_left_reg    <= bytes_left_next;
            saved_ingress_reg <= saved_ingress_next;
            list_active_reg   <= list_active_next;
            final_status_reg  <= final_status_next;
        end
    end

    // a finished list is no longer active, an unfinished one is
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && done |=> !list_active_reg)
        else $error("list still active after a finishing request");

    a_open_stays: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !done |=> list_active_reg)
        else $error("list dropped without a finishing result");

    // begin latches the ingress port
    a_begin_port: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (req.mode == flv_pkg::MODE_BEGIN) |=>
            saved_ingress_reg == $past(req.ingress_port))
        else $error("ingress port not captured on begin");

    // an action header never grows the remaining byte count
    a_bytes_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (req.mode == flv_pkg::MODE_ACTION) |=>
            bytes_left_reg <= $past(bytes_left_reg))
        else $error("remaining bytes grew on an action header");

endmodule
`default_nettype wire

// ===== rtl/flow_action_list_validator.sv =====
// flow_action_list_validator: top level with request/result registers and config registers
//
//  channel  signals                              direction  carries
//  -------  -----------------------------------  ---------  --------------------------------
//  req      req_valid, req_stall, req            in         begin item or one action header
//  rsp      rsp_valid, rsp_stall, rsp            out        status and list-done flag
//  cfg      cfg_valid, cfg_ready, cfg_index,     in         register writes, always ready
//           cfg_data
//
// one request per cycle sustained while the result register is not stalled; a request
// passes the request register, then the combinational header check, then the result register.
// rst_n clears the list state, the handshake valids and loads the register defaults.
// a stalled result holds; the request register keeps accepting while the result
// register is free or being drained in the same cycle.
`default_nettype none
module flow_action_list_validator #(
    parameter int TABLE_ENTRIES = flv_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_stall,
    input  wire flv_pkg::flv_req_t              req,
    output logic                                rsp_valid,
    input  wire logic                           rsp_stall,
    output flv_pkg::flv_rsp_t                   rsp,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [flv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [63:0]                    cfg_data
);

    localparam int TABLE_W = 4 * TABLE_ENTRIES;

    logic                 req_valid_reg;
    flv_pkg::flv_req_t    req_reg;
    logic                 rsp_valid_reg;
    flv_pkg::flv_rsp_t    rsp_reg;
    flv_pkg::flv_rsp_t    rsp_next;
    logic [TABLE_W-1:0]   tbl_reg;
    flv_pkg::flv_cfg_t    cfg_reg;
    logic                 advance;
    logic                 fire;
    logic                 cfg_wr;

    // pipeline handshake
    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign fire      = req_valid_reg && advance;
    assign req_stall = req_valid_reg && !advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            req_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_reg <= req;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_reg                    <= flv_pkg::RST_TYPE_LENGTH_TABLE[TABLE_W-1:0];
            cfg_reg.builtin_type_count <= flv_pkg::RST_BUILTIN_TYPE_COUNT;
            cfg_reg.vendor_type_code   <= flv_pkg::RST_VENDOR_TYPE_CODE;
            cfg_reg.accepted_vendor    <= flv_pkg::RST_ACCEPTED_VENDOR;
            cfg_reg.no_port_value      <= flv_pkg::RST_NO_PORT_VALUE;
            cfg_reg.output_type_code   <= flv_pkg::RST_OUTPUT_TYPE_CODE;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                flv_pkg::REG_TYPE_LENGTH_TABLE:  tbl_reg <= cfg_data[TABLE_W-1:0];
                flv_pkg::REG_BUILTIN_TYPE_COUNT: cfg_reg.builtin_type_count <= cfg_data[4:0];
                flv_pkg::REG_VENDOR_TYPE_CODE:   cfg_reg.vendor_type_code <= cfg_data[15:0];
                flv_pkg::REG_ACCEPTED_VENDOR:    cfg_reg.accepted_vendor <= cfg_data[31:0];
                flv_pkg::REG_NO_PORT_VALUE:      cfg_reg.no_port_value <= cfg_data[15:0];
                flv_pkg::REG_OUTPUT_TYPE_CODE:   cfg_reg.output_type_code <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // header check and list state
    flv_core #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (req_reg),
        .tbl   (tbl_reg),
        .cfg   (cfg_reg),
        .rsp   (rsp_next)
    );

    // every moved request produces a result next cycle
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> rsp_valid_reg)
        else $error("request moved but no result appeared");

    // stall only while a request is held
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> req_valid_reg)
        else $error("stall raised with an empty request register");

    // a held request behind a blocked result must stall the input
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_stall && req_valid_reg |-> req_stall && !fire)
        else $error("request moved into a blocked result register");

endmodule
`default_nettype wire

// ===== bench/tb_flow_action_list_validator.sv =====
// tb_flow_action_list_validator: self-checking bench for the flow action list validator
`default_nettype none
module tb_flow_action_list_validator;
    import flv_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    flv_req_t             req;
    logic                 rsp_valid;
    logic                 rsp_stall;
    flv_rsp_t             rsp;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;

    // shadow copy of the configuration registers
    logic [63:0] len_table   = RST_TYPE_LENGTH_TABLE;
    logic [4:0]  type_count  = RST_BUILTIN_TYPE_COUNT;
    logic [15:0] vendor_code = RST_VENDOR_TYPE_CODE;
    logic [31:0] vendor_id   = RST_ACCEPTED_VENDOR;
    logic [15:0] no_port     = RST_NO_PORT_VALUE;
    logic [3:0]  out_type    = RST_OUTPUT_TYPE_CODE;

    // shadow copy of the list state
    logic [15:0] list_bytes  = '0;
    logic [15:0] flow_port   = '0;
    logic        list_open   = 1'b0;
    logic [2:0]  last_status = ST_OK;

    flv_rsp_t verdict_q[$];
    int       mismatches = 0;
    logic     gaps_on    = 1'b0;
    logic     stalls_on  = 1'b0;

    flow_action_list_validator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // run limit
    initial
    begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

    // header check against the current list and configuration
    function automatic logic [2:0] judge_header(input logic [15:0] atype,
                                                input logic [15:0] alen,
                                                input logic [15:0] tport,
                                                input logic [31:0] vid);
        int unsigned cnt;
        logic [3:0]  units;
        cnt = (type_count > 16) ? 16 : type_count;
        if (alen == 16'd0 || alen > list_bytes || alen[2:0] != 3'd0)
            return ST_BAD_LEN;
        if (atype < cnt)
        begin
            units = len_table[4*atype[3:0] +: 4];
            if (units == 4'd0)
                return ST_BAD_TYPE;
            if (alen != {9'd0, units, 3'd0})
                return ST_BAD_LEN;
            if (atype == {12'd0, out_type} && (tport == no_port || tport == flow_port))
                return ST_BAD_PORT;
            return ST_OK;
        end
        if (atype == vendor_code)
        begin
            if (alen < HDR_BYTES)
                return ST_BAD_LEN;
            if (vid != vendor_id)
                return ST_BAD_VENDOR;
            return ST_OK;
        end
        return ST_BAD_TYPE;
    endfunction

    // expected result of one request, advancing the list state
    function automatic flv_rsp_t predict_verdict(input flv_req_t r);
        flv_rsp_t v;
        v.status   = ST_OK;
        v.done_res = 1'b0;
        if (r.mode == MODE_BEGIN)
        begin
            list_bytes = r.list_length;
            flow_port  = r.ingress_port;
            list_open  = 1'b1;
            if (list_bytes < HDR_BYTES)
            begin
                v.done_res = 1'b1;
                v.status   = (list_bytes != 16'd0) ? ST_BAD_LEN : ST_OK;
            end
        end
        else if (!list_open)
        begin
            v.status   = last_status;
            v.done_res = 1'b1;
        end
        else
        begin
            v.status = judge_header(r.action_type, r.action_len, r.target_port, r.vendor_word);
            if (v.status != ST_OK)
                v.done_res = 1'b1;
            else
            begin
                list_bytes = list_bytes - r.action_len;
                if (list_bytes < HDR_BYTES)
                begin
                    v.done_res = 1'b1;
                    v.status   = (list_bytes != 16'd0) ? ST_BAD_LEN : ST_OK;
                end
            end
        end
        if (v.done_res && list_open)
        begin
            list_open   = 1'b0;
            last_status = v.status;
        end
        return v;
    endfunction

    function automatic flv_req_t make_begin(input logic [15:0] len, input logic [15:0] port);
        flv_req_t r;
        r.mode         = MODE_BEGIN;
        r.list_length  = len;
        r.ingress_port = port;
        r.action_type  = 16'($urandom);
        r.action_len   = 16'($urandom);
        r.target_port  = 16'($urandom);
        r.vendor_word  = $urandom;
        return r;
    endfunction

    function automatic flv_req_t make_action(input logic [15:0] atype, input logic [15:0] alen,
                                             input logic [15:0] tport, input logic [31:0] vid);
        flv_req_t r;
        r.mode         = MODE_ACTION;
        r.list_length  = 16'($urandom);
        r.ingress_port = 16'($urandom);
        r.action_type  = atype;
        r.action_len   = alen;
        r.target_port  = tport;
        r.vendor_word  = vid;
        return r;
    endfunction

    // an action header passing every check, or noise if no type can pass
    function automatic flv_req_t legal_action(input logic [15:0] port_in);
        logic [15:0] kinds[$];
        logic [15:0] t;
        logic [15:0] len;
        logic [15:0] p;
        int unsigned cnt;
        cnt = (type_count > 16) ? 16 : type_count;
        for (int i = 0; i < cnt; i++)
            if (len_table[4*i +: 4] != 4'd0)
                kinds.push_back(16'(i));
        if (vendor_code >= cnt)
            kinds.push_back(vendor_code);
        if (kinds.size() == 0)
        begin
            len = 16'(8 * $urandom_range(0, 4));
            return make_action(16'($urandom), len, 16'($urandom), $urandom);
        end
        t = kinds[$urandom_range(0, kinds.size() - 1)];
        p = 16'($urandom);
        if (t >= cnt)
        begin
            len = 16'(8 * $urandom_range(1, 4));
            return make_action(t, len, p, vendor_id);
        end
        len = {9'd0, len_table[4*t[3:0] +: 4], 3'd0};
        if (t == {12'd0, out_type})
            while (p == no_port || p == port_in)
                p = 16'($urandom);
        return make_action(t, len, p, $urandom);
    endfunction

    // request side: random gap, then hold until accepted
    task automatic send_req(input flv_req_t r);
        int gap;
        gap = gaps_on ? $urandom_range(0, 11) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       = r;
        req_valid = 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_for_idle();
        @(negedge clk);
        req_valid = 1'b0;
        while (verdict_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_TYPE_LENGTH_TABLE:  len_table   = data;
            REG_BUILTIN_TYPE_COUNT: type_count  = data[4:0];
            REG_VENDOR_TYPE_CODE:   vendor_code = data[15:0];
            REG_ACCEPTED_VENDOR:    vendor_id   = data[31:0];
            REG_NO_PORT_VALUE:      no_port     = data[15:0];
            REG_OUTPUT_TYPE_CODE:   out_type    = data[3:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic [63:0] tbl, input logic [4:0] cnt,
                              input logic [15:0] vcode, input logic [31:0] vid,
                              input logic [15:0] nport, input logic [3:0] otype);
        wait_for_idle();
        write_reg(REG_TYPE_LENGTH_TABLE, tbl);
        write_reg(REG_BUILTIN_TYPE_COUNT, {59'd0, cnt});
        write_reg(REG_VENDOR_TYPE_CODE, {48'd0, vcode});
        write_reg(REG_ACCEPTED_VENDOR, {32'd0, vid});
        write_reg(REG_NO_PORT_VALUE, {48'd0, nport});
        write_reg(REG_OUTPUT_TYPE_CODE, {60'd0, otype});
    endtask

    // mostly well-formed lists with random content, some broken, the rest noise
    task automatic run_lists(input int n);
        int          sent;
        int          next_redraw;
        int          k;
        int          pick;
        int          tail;
        int unsigned cnt;
        logic [15:0] total;
        logic [15:0] port_in;
        logic [3:0]  units;
        flv_req_t    acts[$];
        flv_req_t    a;
        sent        = 0;
        next_redraw = 0;
        while (sent < n)
        begin
            // idling modes change now and then, sometimes both off
            if (sent >= next_redraw)
            begin
                gaps_on     = ($urandom_range(0, 3) != 0);
                stalls_on   = ($urandom_range(0, 3) != 0);
                next_redraw = sent + 40;
            end
            if ($urandom_range(0, 99) < 80)
            begin
                acts.delete();
                total   = 16'd0;
                port_in = 16'($urandom);
                k       = $urandom_range(1, 6);
                repeat (k)
                begin
                    a = legal_action(port_in);
                    acts.push_back(a);
                    total += a.action_len;
                end
                // break one header of the list
                if ($urandom_range(0, 2) == 0)
                begin
                    pick = $urandom_range(0, k - 1);
                    a    = acts[pick];
                    cnt  = (type_count > 16) ? 16 : type_count;
                    case ($urandom_range(0, 5))
                        0: a.action_len = 16'd0;
                        1: a.action_len = a.action_len + 16'($urandom_range(1, 7));
                        2: a.action_len = a.action_len + 16'd8;
                        3: a.action_type = 16'($urandom);
                        4:
                        begin
                            a.action_type = vendor_code;
                            a.vendor_word = ~vendor_id;
                        end
                        default:
                        begin
                            a.action_type = {12'd0, out_type};
                            units = len_table[4*out_type +: 4];
                            if (out_type < cnt && units != 4'd0)
                                a.action_len = {9'd0, units, 3'd0};
                            a.target_port = $urandom_range(0, 1) ? no_port : port_in;
                        end
                    endcase
                    acts[pick] = a;
                end
                case ($urandom_range(0, 7))
                    0:       tail = $urandom_range(1, 7);
                    1:       tail = $urandom_range(8, 40);
                    default: tail = 0;
                endcase
                send_req(make_begin(total + 16'(tail), port_in));
                sent++;
                foreach (acts[i])
                begin
                    send_req(acts[i]);
                    sent++;
                end
            end
            else
            begin
                a.mode         = 1'($urandom_range(0, 1));
                a.list_length  = $urandom_range(0, 1) ? 16'($urandom)
                                                      : 16'(8 * $urandom_range(0, 12));
                a.ingress_port = 16'($urandom);
                a.action_type  = $urandom_range(0, 1) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 20));
                a.action_len   = $urandom_range(0, 1) ? 16'($urandom)
                                                      : 16'(8 * $urandom_range(0, 16));
                a.target_port  = $urandom_range(0, 1) ? 16'($urandom) : no_port;
                a.vendor_word  = $urandom_range(0, 1) ? $urandom : vendor_id;
                send_req(a);
                sent++;
            end
        end
    endtask

    // field extremes, both modes and the list corner cases under reset settings
    task automatic test_reset_config();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_req(make_action(16'd1, 16'd8, 16'd0, 32'd0));
        send_req(make_begin(16'd0, 16'd0));
        send_req(make_begin(16'd5, 16'd1));
        send_req(make_action(16'd1, 16'd8, 16'd0, 32'd0));
        send_req(make_begin(16'hFFFF, 16'hFFFF));
        send_req(make_action(16'hFFFF, 16'hFFF8, 16'hFFFF, 32'hFFFF_FFFF));
        send_req(make_begin(16'd64, 16'd3));
        send_req(make_action(16'd0, 16'd8, 16'd5, 32'd0));
        send_req(make_action(16'd0, 16'd8, 16'd3, 32'd0));
        send_req(make_begin(16'd64, 16'd3));
        send_req(make_action(16'd0, 16'd8, 16'hFFFF, 32'd0));
        send_req(make_begin(16'd40, 16'd7));
        send_req(make_action(16'd4, 16'd16, 16'd0, 32'd0));
        send_req(make_action(16'd2, 16'd0, 16'd0, 32'd0));
        send_req(make_begin(16'd40, 16'd7));
        send_req(make_action(16'd4, 16'd8, 16'd0, 32'd0));
        send_req(make_begin(16'd8, 16'd7));
        send_req(make_action(16'd4, 16'd16, 16'd0, 32'd0));
        send_req(make_begin(16'd12, 16'd0));
        send_req(make_action(16'd1, 16'd8, 16'd0, 32'd0));
        send_req(make_begin(16'd64, 16'd0));
        send_req(make_action(16'hFFFF, 16'd16, 16'd0, 32'd8992));
        send_req(make_action(16'd10, 16'd8, 16'd0, 32'd0));
        send_req(make_begin(16'd64, 16'd0));
        send_req(make_begin(16'd16, 16'd0));
        send_req(make_action(16'd6, 16'd12, 16'd0, 32'd0));
        run_lists(150);
    endtask

    // zero entries in the length table mark undefined types
    task automatic test_undefined_types();
        set_config(64'hF0F0_0F00_F0F0_0F0F, 5'd16, 16'h0100, 32'd0, 16'd0, 4'd15);
        send_req(make_begin(16'd240, 16'd1));
        send_req(make_action(16'd1, 16'd8, 16'd2, 32'd0));
        send_req(make_begin(16'd240, 16'd1));
        send_req(make_action(16'd15, 16'd120, 16'd0, 32'd0));
        run_lists(150);
    endtask

    // a vendor code below the type count is handled as a built-in type
    task automatic test_vendor_in_builtin();
        set_config(RST_TYPE_LENGTH_TABLE, 5'd10, 16'd3, 32'hFFFF_FFFF, 16'hFFFF, 4'd3);
        send_req(make_begin(16'd32, 16'd9));
        send_req(make_action(16'd3, 16'd8, 16'd4, 32'd1));
        send_req(make_action(16'd3, 16'd16, 16'd4, 32'hFFFF_FFFF));
        run_lists(150);
    endtask

    // type count above the table size saturates
    task automatic test_count_saturation();
        set_config(64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 16'hFFFF, 32'd0, 16'h1234, 4'd7);
        send_req(make_begin(16'd240, 16'd5));
        send_req(make_action(16'd15, 16'd120, 16'd0, 32'd0));
        send_req(make_action(16'd16, 16'd8, 16'd0, 32'd0));
        run_lists(150);
        set_config(64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 16'd16, 32'd0, 16'h1234, 4'd7);
        run_lists(60);
    endtask

    // no built-in types at all, vendor action on code zero
    task automatic test_empty_table();
        set_config(64'd0, 5'd0, 16'd0, 32'd8992, 16'hFFFF, 4'd0);
        run_lists(120);
    endtask

    task automatic test_random_configs();
        logic [63:0] tbl;
        repeat (3)
        begin
            for (int i = 0; i < 16; i++)
                tbl[4*i +: 4] = ($urandom_range(0, 3) == 0) ? 4'd0
                                                            : 4'($urandom_range(1, 15));
            set_config(tbl, 5'($urandom_range(0, 20)),
                       $urandom_range(0, 1) ? 16'($urandom_range(0, 20)) : 16'($urandom),
                       $urandom, $urandom_range(0, 1) ? 16'($urandom) : 16'hFFFF,
                       4'($urandom_range(0, 15)));
            run_lists(110);
        end
    endtask

    // result side: random stall before each result
    initial
    begin : stall_driver
        int n;
        rsp_stall = 1'b0;
        forever
        begin
            n = stalls_on ? $urandom_range(0, 11) : 0;
            @(negedge clk);
            rsp_stall = (n != 0);
            repeat (n) @(negedge clk);
            rsp_stall = 1'b0;
            @(posedge clk);
            while (!(rsp_valid && !rsp_stall))
                @(posedge clk);
        end
    end

    // predict every accepted request
    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
            verdict_q.push_back(predict_verdict(req));
    end

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // compare every accepted result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        flv_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (verdict_q.size() == 0)
                log_mismatch($sformatf("unexpected result status %0d done %0d",
                                       rsp.status, rsp.done_res));
            else
            begin
                want = verdict_q.pop_front();
                if (rsp.status != want.status || rsp.done_res != want.done_res)
                    log_mismatch($sformatf("expected status %0d done %0d, got status %0d done %0d",
                                           want.status, want.done_res,
                                           rsp.status, rsp.done_res));
            end
        end
    end

    // reset, tests in turn, final verdict
    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_reset_config();
        test_undefined_types();
        test_vendor_in_builtin();
        test_count_saturation();
        test_empty_table();
        test_random_configs();
        wait_for_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
